// File: src/sfr_pkg.sv
package sfr_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_PATTERN_BYTES      = 3'd0;
  localparam logic [2:0] REG_PATTERN_LENGTH     = 3'd1;
  localparam logic [2:0] REG_REPLACEMENT_BYTES  = 3'd2;
  localparam logic [2:0] REG_REPLACEMENT_LENGTH = 3'd3;
  localparam logic [2:0] REG_FIRST_ONLY         = 3'd4;

  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 4;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_REPL  = 5'b00100,
    ST_FLUSH = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

endpackage

// File: src/stream_find_replace.sv
// Channel  | handshake            | payload
// ---------+----------------------+---------------------------------
// input    | in_valid / in_ready  | data_byte, end_of_text
// output   | out_valid / out_ready| out_byte, byte_valid, last_out
// config   | cfg_we (no wait)     | cfg_index, cfg_data
//
// The candidate scan releases bytes one compare and shift per cycle in the shared prefix
// comparator while the output side keeps up. A replacement releases the replacement bytes,
// and an end-of-stream flush releases the held bytes. Every byte goes through the same
// one-byte staging register. The block takes no new item until the current one's last
// byte has been loaded into the output register.
// Reset clears control state and loads the register defaults; no clearing pass.
// A stalled output holds the sequencer whenever the staging byte cannot move on.
module stream_find_replace #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          end_of_text,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          byte_valid,
  output logic                          last_out
);
  import sfr_pkg::*;

  localparam int CW  = $clog2(MAX_PATTERN + 1);
  localparam int RCW = $clog2(MAX_REPLACEMENT + 1);

  // Configuration registers: byte arrays sized by the parameters, lengths LEN_W bits wide.
  logic [7:0]       pattern_q [MAX_PATTERN];
  logic [7:0]       repl_q    [MAX_REPLACEMENT];
  logic [LEN_W-1:0] pattern_length;
  logic [LEN_W-1:0] replacement_length;
  logic             first_only;

  // Per-stream state. The candidate buffer starts with the held bytes.
  state_t           state;
  logic [7:0]       cand [MAX_PATTERN];
  logic [CW-1:0]    cnt;
  logic             replaced_once;
  logic             eot;
  logic [RCW-1:0]   rep_idx;
  logic [7:0]       pend;
  logic             pend_v;

  logic [LEN_W-1:0] plen;
  logic [LEN_W-1:0] rlen;
  logic             enabled;
  logic             prefix;
  logic             full;
  logic             produce;
  logic [7:0]       gbyte;
  logic             stall;
  logic             step;
  logic             out_free;
  logic             load_out;

  always_comb begin
    if (pattern_length == '0) begin
      plen = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      plen = LEN_W'(MAX_PATTERN);
    end else begin
      plen = pattern_length;
    end
    if (replacement_length > LEN_W'(MAX_REPLACEMENT)) begin
      rlen = LEN_W'(MAX_REPLACEMENT);
    end else begin
      rlen = replacement_length;
    end
  end

  // Shared prefix comparator: the candidate against the pattern over cnt bytes.
  always_comb begin
    prefix = (LEN_W'(cnt) <= plen);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((CW'(i) < cnt) && (cand[i] != pattern_q[i])) begin
        prefix = 1'b0;
      end
    end
  end

  assign enabled  = !(first_only && replaced_once);
  assign full     = (LEN_W'(cnt) == plen);
  assign stall    = pend_v && out_valid && !out_ready;
  assign step     = !stall;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);
  assign load_out = (step && produce && pend_v) ||
                    ((state == ST_FIN) && out_free && (pend_v || eot));

  always_comb begin
    produce = 1'b0;
    gbyte   = cand[0];
    unique case (state)
      ST_SCAN: begin
        produce = (cnt != '0) && !(enabled && prefix);
      end
      ST_FLUSH: begin
        produce = (cnt != '0);
      end
      ST_REPL: begin
        produce = (LEN_W'(rep_idx) != rlen);
        for (int i = 0; i < MAX_REPLACEMENT; i++) begin
          if (RCW'(i) == rep_idx) begin
            gbyte = repl_q[i];
          end
        end
      end
      ST_IDLE, ST_FIN: begin
        produce = 1'b0;
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  // Candidate buffer and staged byte carry no reset.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        if (CW'(i) == cnt) begin
          cand[i] <= data_byte;
        end
      end
    end else if (step && produce && state != ST_REPL) begin
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        cand[i] <= cand[i + 1];
      end
    end
    if (step && produce) begin
      pend <= gbyte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        pattern_q[i] <= '0;
      end
      for (int i = 0; i < MAX_REPLACEMENT; i++) begin
        repl_q[i] <= '0;
      end
      pattern_length     <= LEN_W'(1);
      replacement_length <= '0;
      first_only         <= 1'b0;
      state              <= ST_IDLE;
      cnt                <= '0;
      replaced_once      <= 1'b0;
      eot                <= 1'b0;
      rep_idx            <= '0;
      pend_v             <= 1'b0;
      out_valid          <= 1'b0;
      out_byte           <= '0;
      byte_valid         <= 1'b0;
      last_out           <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PATTERN_BYTES: begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
              pattern_q[i] <= cfg_data[8*i +: 8];
            end
          end
          REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[LEN_W-1:0];
          REG_REPLACEMENT_BYTES: begin
            for (int i = 0; i < MAX_REPLACEMENT; i++) begin
              repl_q[i] <= cfg_data[8*i +: 8];
            end
          end
          REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[LEN_W-1:0];
          REG_FIRST_ONLY:         first_only         <= cfg_data[0];
          default: begin
          end
        endcase
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // A new byte pushes the previously staged one to the output, so the
      // last byte of a stream is still known when it is finally sent.
      if (step && produce && pend_v) begin
        out_byte   <= pend;
        byte_valid <= 1'b1;
        last_out   <= 1'b0;
      end
      if (step && produce) begin
        pend_v <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cnt   <= cnt + 1'b1;
            eot   <= end_of_text;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (step) begin
            if (cnt == '0) begin
              state <= ST_FIN;
            end else if (enabled && prefix) begin
              if (full) begin
                replaced_once <= 1'b1;
                cnt           <= '0;
                rep_idx       <= '0;
                state         <= ST_REPL;
              end else begin
                state <= eot ? ST_FLUSH : ST_FIN;
              end
            end else begin
              cnt <= cnt - 1'b1;
            end
          end
        end
        ST_REPL: begin
          if (step) begin
            if (LEN_W'(rep_idx) == rlen) begin
              state <= ST_FIN;
            end else begin
              rep_idx <= rep_idx + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (step) begin
            if (cnt == '0) begin
              state <= ST_FIN;
            end else begin
              cnt <= cnt - 1'b1;
            end
          end
        end
        ST_FIN: begin
          if (out_free) begin
            if (pend_v) begin
              out_byte   <= pend;
              byte_valid <= 1'b1;
              last_out   <= eot;
              pend_v     <= 1'b0;
            end else if (eot) begin
              // End of stream with nothing to send: empty marker item.
              out_byte   <= '0;
              byte_valid <= 1'b0;
              last_out   <= 1'b1;
            end
            if (eot) begin
              replaced_once <= 1'b0;
              cnt           <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_idle_no_staged: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !pend_v)
    else $error("staged byte left over while idle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_PATTERN))
    else $error("candidate count beyond buffer depth");

  a_marker_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> last_out)
    else $error("empty marker item not flagged as last");

endmodule
